// File: rtl/psa_pkg.sv
package psa_pkg;

    localparam int DIRECTIONS = 32;
    localparam int DIR_IDX_W  = $clog2(DIRECTIONS);
    localparam int DIR_W      = 8;
    localparam int SPEED_W    = 16;
    localparam int SINE_W     = 10;
    localparam int PROD_W     = SINE_W + SPEED_W;
    localparam int FRAC_BITS  = 8;
    localparam int STEP_W     = 16;
    localparam int DY_W       = STEP_W + 1;
    localparam int POS_W      = 32;
    localparam int PIX_W      = POS_W - FRAC_BITS;
    localparam int MOVED_W    = 16;

    localparam logic [DIR_IDX_W-1:0] QUARTER_TURN = DIR_IDX_W'(DIRECTIONS / 4);
    localparam logic [FRAC_BITS-1:0] ROUND_BIAS   = '1;

    // One accepted step on its way from the multipliers to the accumulator.
    typedef struct packed {
        logic                     ok;
        logic signed [STEP_W-1:0] dx;
        logic signed [DY_W-1:0]   dy;
    } step_t;

    // Q2.8 sine for one of the 32 directions, clockwise from up.
    function automatic logic signed [SINE_W-1:0] sine_q8(input logic [DIR_IDX_W-1:0] idx);
        logic [3:0]        k;
        logic [3:0]        f;
        logic [SINE_W-1:0] mag;
        k = idx[3:0];
        // Fold the second quarter turn of each half turn back onto the first.
        f = k[3] ? (4'd0 - k) : k;
        case (f)
            4'd0:    mag = 10'd0;
            4'd1:    mag = 10'd49;
            4'd2:    mag = 10'd97;
            4'd3:    mag = 10'd142;
            4'd4:    mag = 10'd181;
            4'd5:    mag = 10'd212;
            4'd6:    mag = 10'd236;
            4'd7:    mag = 10'd251;
            4'd8:    mag = 10'd256;
            default: mag = 10'd0;
        endcase
        return idx[4] ? -$signed(mag) : $signed(mag);
    endfunction

    // Whole pixels of a Q24.8 position, truncated toward zero.
    function automatic logic signed [PIX_W-1:0] pixel_of(input logic signed [POS_W-1:0] v);
        logic [POS_W-1:0] adj;
        adj = v + (v[POS_W-1] ? POS_W'(ROUND_BIAS) : '0);
        return $signed(adj[POS_W-1:FRAC_BITS]);
    endfunction

endpackage

// File: rtl/psa_in_if.sv
interface psa_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [psa_pkg::DIR_W-1:0]                direction;
    logic signed [psa_pkg::SPEED_W-1:0]       speed;

    modport source (output valid, output direction, output speed, input ready);
    modport sink   (input valid, input direction, input speed, output ready);
endinterface

// File: rtl/psa_out_if.sv
interface psa_out_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     ok;
    logic signed [psa_pkg::MOVED_W-1:0]       moved_x;
    logic signed [psa_pkg::MOVED_W-1:0]       moved_y;

    modport source (output valid, output ok, output moved_x, output moved_y, input ready);
    modport sink   (input valid, input ok, input moved_x, input moved_y, output ready);
endinterface

// File: rtl/polar_step_position_accumulator_core.sv
// Steps a Q24.8 position by a direction (0..31, clockwise from up) and a signed
// Q8.8 speed, and reports the change in whole pixels on each axis. One request
// is accepted every clock cycle unless a stalled report has filled the pipe;
// each result passes the input, step and output registers in turn, and the
// output register lets new requests enter while it waits. The accumulator adds,
// range-checks and commits one step per cycle when its output is free. A step
// with direction 32 or more, or one taking either position outside 32 bits,
// yields ok low, zero movement and an unchanged position. Positions reset to 0.
module polar_step_position_accumulator_core (
    input  logic      clk,
    input  logic      rst_n,
    psa_in_if.sink    move,
    psa_out_if.source report
);
    import psa_pkg::*;

    logic  step_valid;
    logic  step_ready;
    step_t step;

    psa_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .move       (move),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step)
    );

    psa_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step),
        .report     (report)
    );

endmodule

// File: rtl/psa_step.sv
module psa_step (
    input  logic            clk,
    input  logic            rst_n,
    psa_in_if.sink          move,
    output logic            step_valid,
    input  logic            step_ready,
    output psa_pkg::step_t  step
);
    import psa_pkg::*;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [DIR_W-1:0]          dir_reg;
    logic signed [SPEED_W-1:0] speed_reg;

    logic                      step_valid_reg;
    logic                      step_valid_next;
    step_t                     step_reg;
    step_t                     step_next;

    logic                      step_free;
    logic                      in_take;

    logic [DIR_IDX_W-1:0]      sin_idx;
    logic [DIR_IDX_W-1:0]      cos_idx;
    logic signed [SINE_W-1:0]  sin_val;
    logic signed [SINE_W-1:0]  cos_val;
    logic signed [PROD_W-1:0]  prod_s;
    logic signed [PROD_W-1:0]  prod_c;
    logic [PROD_W-1:0]         adj_s;
    logic [PROD_W-1:0]         adj_c;
    logic signed [STEP_W-1:0]  q_c;

    assign step_free = !step_valid_reg || step_ready;
    assign in_take   = !in_valid_reg || step_free;
    assign move.ready = in_take;

    assign sin_idx = dir_reg[DIR_IDX_W-1:0];
    assign cos_idx = dir_reg[DIR_IDX_W-1:0] + QUARTER_TURN;
    assign sin_val = sine_q8(sin_idx);
    assign cos_val = sine_q8(cos_idx);

    assign prod_s = PROD_W'(sin_val) * PROD_W'(speed_reg);
    assign prod_c = PROD_W'(cos_val) * PROD_W'(speed_reg);

    // Biasing a negative product before the shift rounds it toward zero;
    // the 16 bits above the fraction are the wrapped step.
    assign adj_s = prod_s + (prod_s[PROD_W-1] ? PROD_W'(ROUND_BIAS) : '0);
    assign adj_c = prod_c + (prod_c[PROD_W-1] ? PROD_W'(ROUND_BIAS) : '0);
    assign q_c   = $signed(adj_c[FRAC_BITS+STEP_W-1:FRAC_BITS]);

    always_comb
    begin
        in_valid_next = in_take ? move.valid : in_valid_reg;
        step_valid_next = step_free ? in_valid_reg : step_valid_reg;
        step_next.ok = (dir_reg < DIR_W'(DIRECTIONS));
        step_next.dx = $signed(adj_s[FRAC_BITS+STEP_W-1:FRAC_BITS]);
        // The negated cosine step is kept unwrapped, so it needs one more bit.
        step_next.dy = -DY_W'(q_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            step_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            step_valid_reg <= step_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && move.valid)
        begin
            dir_reg   <= move.direction;
            speed_reg <= move.speed;
        end
        if (step_free && in_valid_reg)
        begin
            step_reg <= step_next;
        end
    end

    assign step_valid = step_valid_reg;
    assign step       = step_reg;

endmodule

// File: rtl/psa_accum.sv
module psa_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_valid,
    output logic            step_ready,
    input  psa_pkg::step_t  step,
    psa_out_if.source       report
);
    import psa_pkg::*;

    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic signed [POS_W-1:0]   pos_x_next;
    logic signed [POS_W-1:0]   pos_y_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      ok_reg;
    logic                      ok_next;
    logic signed [MOVED_W-1:0] moved_x_reg;
    logic signed [MOVED_W-1:0] moved_y_reg;
    logic signed [MOVED_W-1:0] moved_x_next;
    logic signed [MOVED_W-1:0] moved_y_next;

    logic                      out_free;
    logic                      take;
    logic signed [POS_W:0]     sum_x;
    logic signed [POS_W:0]     sum_y;
    logic                      fits;
    logic signed [PIX_W-1:0]   pix_dx;
    logic signed [PIX_W-1:0]   pix_dy;

    assign out_free   = !out_valid_reg || report.ready;
    assign step_ready = out_free;
    assign take       = step_valid && out_free;

    assign sum_x = (POS_W+1)'(pos_x_reg) + (POS_W+1)'(step.dx);
    assign sum_y = (POS_W+1)'(pos_y_reg) + (POS_W+1)'(step.dy);
    // A sum stays in range when its two top bits agree.
    assign fits  = (sum_x[POS_W] == sum_x[POS_W-1]) && (sum_y[POS_W] == sum_y[POS_W-1]);

    assign pix_dx = pixel_of(sum_x[POS_W-1:0]) - pixel_of(pos_x_reg);
    assign pix_dy = pixel_of(sum_y[POS_W-1:0]) - pixel_of(pos_y_reg);

    always_comb
    begin
        out_valid_next = out_free ? step_valid : out_valid_reg;
        ok_next        = step.ok && fits;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        moved_x_next   = '0;
        moved_y_next   = '0;
        if (take && ok_next)
        begin
            pos_x_next   = sum_x[POS_W-1:0];
            pos_y_next   = sum_y[POS_W-1:0];
            moved_x_next = pix_dx[MOVED_W-1:0];
            moved_y_next = pix_dy[MOVED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ok_reg      <= ok_next;
            moved_x_reg <= moved_x_next;
            moved_y_reg <= moved_y_next;
        end
    end

    assign report.valid   = out_valid_reg;
    assign report.ok      = ok_reg;
    assign report.moved_x = moved_x_reg;
    assign report.moved_y = moved_y_reg;

`ifndef SYNTHESIS
    a_pos_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("position moved without a request");

    a_pos_hold_reject: assert property (@(posedge clk) disable iff (!rst_n)
        take && !ok_next |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("rejected request changed the position");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> moved_x_reg == '0 && moved_y_reg == '0)
        else $error("rejected request reports movement");

    a_load_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("accepted step produced no result");
`endif

endmodule

// File: tb/psa_position_tracker.sv
`timescale 1ns / 1ps
module psa_position_tracker (
    input  logic clk,
    input  logic rst_n,
    psa_in_if    move,
    psa_out_if   report,
    output int   bad_reports,
    output int   reports_due
);
    import psa_pkg::*;

    localparam longint POS_MIN     = -64'sd2147483648;
    localparam longint POS_MAX     = 64'sd2147483647;
    localparam int     SHOWN_LIMIT = 10;

    typedef struct {
        logic                      ok;
        logic signed [MOVED_W-1:0] moved_x;
        logic signed [MOVED_W-1:0] moved_y;
    } move_report_t;

    move_report_t moves_due[$];
    int           pos_x = 0;
    int           pos_y = 0;
    int           fail_count = 0;
    int           report_count = 0;

    assign bad_reports = fail_count;

    // Q2.8 sine, clockwise from up; the second half turn mirrors the first.
    function automatic int sine_of(input int idx);
        int mag;
        case (idx % 16)
            0:       mag = 0;
            1:       mag = 49;
            2:       mag = 97;
            3:       mag = 142;
            4:       mag = 181;
            5:       mag = 212;
            6:       mag = 236;
            7:       mag = 251;
            8:       mag = 256;
            9:       mag = 251;
            10:      mag = 236;
            11:      mag = 212;
            12:      mag = 181;
            13:      mag = 142;
            14:      mag = 97;
            default: mag = 49;
        endcase
        return (idx >= 16) ? -mag : mag;
    endfunction

    // Product shifted down by eight towards zero, then wrapped to 16 bits.
    function automatic longint q8_scale(input int s, input int spd);
        longint             prod;
        longint             shifted;
        logic signed [15:0] wrapped;
        prod    = longint'(s) * longint'(spd);
        shifted = prod / 256;
        wrapped = shifted[15:0];
        return longint'(wrapped);
    endfunction

    function automatic longint whole_pixels(input longint v);
        return v / 256;
    endfunction

    task automatic predict_move(input int dir, input int spd, output move_report_t r);
        longint dx;
        longint dy;
        longint nx;
        longint ny;
        r.ok      = 1'b0;
        r.moved_x = '0;
        r.moved_y = '0;
        if (dir < DIRECTIONS)
        begin
            dx = q8_scale(sine_of(dir), spd);
            dy = -q8_scale(sine_of((dir + DIRECTIONS / 4) % DIRECTIONS), spd);
            nx = longint'(pos_x) + dx;
            ny = longint'(pos_y) + dy;
            // A step that would leave the 32-bit range on either axis is dropped whole.
            if (nx >= POS_MIN && nx <= POS_MAX && ny >= POS_MIN && ny <= POS_MAX)
            begin
                r.ok      = 1'b1;
                r.moved_x = MOVED_W'(whole_pixels(nx) - whole_pixels(longint'(pos_x)));
                r.moved_y = MOVED_W'(whole_pixels(ny) - whole_pixels(longint'(pos_y)));
                pos_x     = int'(nx);
                pos_y     = int'(ny);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        move_report_t want;
        move_report_t next_move;
        if (!rst_n)
        begin
            moves_due.delete();
            pos_x       = 0;
            pos_y       = 0;
            reports_due <= 0;
        end
        else
        begin
            // Results come out only after their request has passed the registers, so the
            // oldest expectation is checked before this cycle's request is added.
            if (report.valid && report.ready)
            begin
                report_count++;
                if (moves_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_LIMIT)
                        $display("report %0d arrived with nothing outstanding: ok=%0b x=%0d y=%0d",
                                 report_count, report.ok, report.moved_x, report.moved_y);
                end
                else
                begin
                    want = moves_due.pop_front();
                    if (report.ok !== want.ok || report.moved_x !== want.moved_x ||
                        report.moved_y !== want.moved_y)
                    begin
                        fail_count++;
                        if (fail_count <= SHOWN_LIMIT)
                            $display("report %0d: expected ok=%0b x=%0d y=%0d, got ok=%0b x=%0d y=%0d",
                                     report_count, want.ok, want.moved_x, want.moved_y,
                                     report.ok, report.moved_x, report.moved_y);
                    end
                end
            end
            if (move.valid && move.ready)
            begin
                predict_move(int'(move.direction), int'(move.speed), next_move);
                moves_due.push_back(next_move);
            end
            reports_due <= moves_due.size();
        end
    end

endmodule

// File: tb/tb_polar_step_position_accumulator_core.sv
`timescale 1ns / 1ps
module tb_polar_step_position_accumulator_core;
    import psa_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   quiet_cycles;
    int   bad_reports;
    int   reports_due;

    psa_in_if  move_ch();
    psa_out_if report_ch();

    polar_step_position_accumulator_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .move   (move_ch),
        .report (report_ch)
    );

    psa_position_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .move        (move_ch),
        .report      (report_ch),
        .bad_reports (bad_reports),
        .reports_due (reports_due)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        report_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((move_ch.valid && move_ch.ready) || (report_ch.valid && report_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_step(input logic [DIR_W-1:0] dir, input logic signed [SPEED_W-1:0] spd);
        while ($urandom_range(99) < src_idle_pct)
        begin
            move_ch.valid <= 1'b0;
            @(negedge clk);
        end
        move_ch.valid     <= 1'b1;
        move_ch.direction <= dir;
        move_ch.speed     <= spd;
        @(posedge clk);
        while (!move_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_all_reported();
        move_ch.valid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
    endtask

    function automatic logic [DIR_W-1:0] rand_direction();
        if ($urandom_range(99) < 88)
            return DIR_W'($urandom_range(DIRECTIONS - 1));
        return DIR_W'($urandom_range(255, DIRECTIONS));
    endfunction

    function automatic logic signed [SPEED_W-1:0] rand_speed();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SPEED_W'($urandom_range(600) - 300);
            3:       return SPEED_W'($urandom_range(2) - 1);
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    task automatic random_steps(input int count);
        repeat (count)
            send_step(rand_direction(), rand_speed());
    endtask

    initial
    begin
        rst_n             = 1'b0;
        move_ch.valid     = 1'b0;
        move_ch.direction = '0;
        move_ch.speed     = '0;
        report_ch.ready   = 1'b0;
        src_idle_pct      = 11;
        snk_idle_pct      = 45;
        quiet_cycles      = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The four compass points and the diagonals between them.
        send_step(8'd0, 16'sd256);
        send_step(8'd8, 16'sd256);
        send_step(8'd16, 16'sd256);
        send_step(8'd24, 16'sd256);
        send_step(8'd4, 16'sd1000);
        send_step(8'd12, -16'sd1000);
        send_step(8'd20, 16'sd777);
        send_step(8'd28, -16'sd777);
        // Tiny speeds whose products round towards zero.
        send_step(8'd1, -16'sd1);
        send_step(8'd1, 16'sd1);
        send_step(8'd3, -16'sd200);
        send_step(8'd31, 16'sd0);
        // Full-scale speeds, including the two that wrap past 16 bits.
        send_step(8'd7, 16'sh7fff);
        send_step(8'd24, 16'sh8000);
        send_step(8'd16, 16'sh8000);
        send_step(8'd8, 16'sh8000);
        send_step(8'd0, 16'sh7fff);
        // Directions outside the circle.
        send_step(8'd32, 16'sd100);
        send_step(8'd255, -16'sd1);
        send_step(8'd200, 16'sd12345);

        random_steps(600);
        wait_all_reported();

        src_idle_pct = 45;
        snk_idle_pct = 11;
        random_steps(600);
        wait_all_reported();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_steps(550);

        wait_all_reported();
        repeat (8) @(negedge clk);
        if (bad_reports == 0 && reports_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
